// ===== design/prs80_pkg.sv =====
// ---------------------------------------------------------------------------
// prs80_pkg
// Shared types, constants and layer functions for the PRESENT-80 encryptor.
// ---------------------------------------------------------------------------
package prs80_pkg;

   localparam int BlockWidth = 64;
   localparam int KeyWidth   = 80;
   localparam int NumRounds  = 31;
   localparam int CntWidth   = 5;

   // Register byte addresses (64-bit data port, 8-byte stride)
   localparam logic [3:0] AddrKeyHigh = 4'h0;
   localparam logic [3:0] AddrKeyLow  = 4'h8;

   // One pipeline slot: the data block travels with its own key register
   typedef struct packed {
      logic                  valid;
      logic [BlockWidth-1:0] state;
      logic [KeyWidth-1:0]   key;
   } stage_type;

   // 4-bit S-box
   function automatic logic [3:0] sbox4(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         4'hF: y = 4'h2;
         default: y = 4'h0;
      endcase
      return y;
   endfunction

   // S-box on all sixteen nibbles
   function automatic logic [BlockWidth-1:0] sbox_layer(input logic [BlockWidth-1:0] s);
      logic [BlockWidth-1:0] o;
      o = '0;
      for (int i = 0; i < BlockWidth / 4; i++) begin
         o[4*i +: 4] = sbox4(s[4*i +: 4]);
      end
      return o;
   endfunction

   // Bit i moves to 16*i mod 63, i.e. 16*(i mod 4) + i/4; bit 63 stays put
   function automatic logic [BlockWidth-1:0] perm_layer(input logic [BlockWidth-1:0] s);
      logic [BlockWidth-1:0] o;
      o = '0;
      for (int i = 0; i < BlockWidth; i++) begin
         o[((i & 3) * 16) + (i >> 2)] = s[i];
      end
      return o;
   endfunction

   // Key register update: rotate left 61, S-box top nibble, counter into bits 19..15
   function automatic logic [KeyWidth-1:0] key_update(input logic [KeyWidth-1:0] k,
                                                      input logic [CntWidth-1:0] cnt);
      logic [KeyWidth-1:0] n;
      n = {k[18:0], k[79:19]};
      n[79:76] = sbox4(n[79:76]);
      n[19:15] = n[19:15] ^ cnt;
      return n;
   endfunction

endpackage

// ===== design/prs80_round.sv =====
// ---------------------------------------------------------------------------
// prs80_round
// One registered PRESENT round: key add, S-box layer, bit permutation, with
// the key register advanced to the next round key alongside.
// ---------------------------------------------------------------------------
module prs80_round (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [prs80_pkg::CntWidth-1:0] round_cnt,
   input  prs80_pkg::stage_type           stage_in,
   output prs80_pkg::stage_type           stage_out
);
   import prs80_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [BlockWidth-1:0] state_ff;
   logic [BlockWidth-1:0] state_in;
   logic [KeyWidth-1:0]   key_ff;
   logic [KeyWidth-1:0]   key_in;

   // round datapath
   always_comb begin
      valid_in = stage_in.valid;
      state_in = perm_layer(sbox_layer(stage_in.state ^ stage_in.key[KeyWidth-1 -: BlockWidth]));
      key_in   = key_update(stage_in.key, round_cnt);
   end

   // slot valid, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   assign stage_out = '{valid: valid_ff, state: state_ff, key: key_ff};

endmodule

// ===== design/present80_block_encrypt_core.sv =====
// ---------------------------------------------------------------------------
// present80_block_encrypt_core
// PRESENT-80 block encryption, fully pipelined, one block per clock unless stalled.
// ---------------------------------------------------------------------------
// Takes one 64-bit plaintext beat per cycle while not stalled and returns its
// ciphertext through 31 registered round stages, then an output register that
// applies the last key addition. Each block carries its own 80-bit key
// register down the pipeline, so the round keys are built stage by stage and
// need no precomputation. A back-pressured output stalls the whole pipeline;
// a one-entry input buffer still takes one beat while stalled. The key sits
// at byte address 0 (bits 79..16) and 8 (bits 15..0) and is to be written
// only while no block is in flight.
module present80_block_encrypt_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] plaintext
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] ciphertext
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import prs80_pkg::*;

   logic [63:0]           key_high_ff;
   logic [15:0]           key_low_ff;
   logic                  csr_wr;

   logic                  skid_valid_ff;
   logic [BlockWidth-1:0] skid_data_ff;
   logic                  req_accept;
   logic                  pipe_en;

   stage_type             pipe [0:NumRounds];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [BlockWidth-1:0] rsp_data_ff;
   logic [BlockWidth-1:0] rsp_data_in;

   // register port: full address decode, other addresses ignored
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr)
         AddrKeyHigh: csr_prdata = key_high_ff;
         AddrKeyLow:  csr_prdata = {48'd0, key_low_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_paddr)
            AddrKeyHigh: key_high_ff <= csr_pwdata;
            AddrKeyLow:  key_low_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output slot is free or being drained
   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   // input buffer catches one beat during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_en && req_accept) begin
         skid_data_ff <= req_tdata;
      end
   end

   // pipeline entry: buffered beat first, else the live one
   always_comb begin
      pipe[0].valid = skid_valid_ff || req_accept;
      pipe[0].state = skid_valid_ff ? skid_data_ff : req_tdata;
      pipe[0].key   = {key_high_ff, key_low_ff};
   end

   // round stages
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      prs80_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (pipe_en),
         .round_cnt (CntWidth'(g + 1)),
         .stage_in  (pipe[g]),
         .stage_out (pipe[g+1])
      );
   end

   // output register with the final key addition
   assign rsp_valid_in = pipe[NumRounds].valid;
   assign rsp_data_in  = pipe[NumRounds].state ^ pipe[NumRounds].key[KeyWidth-1 -: BlockWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // buffer only fills on a stall
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !$past(skid_valid_ff)) |-> $past(!pipe_en))
      else $error("input buffer filled while pipeline was moving");

   // a filled buffer drains on the next move
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pipe_en) |=> !skid_valid_ff)
      else $error("input buffer not drained");

   // stalled pipeline keeps its slots
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> ($stable(pipe[1].valid) && $stable(pipe[NumRounds].valid)
                    && $stable(pipe[NumRounds].state)))
      else $error("pipeline slot changed during stall");
`endif

endmodule
